### rtl/cst_pkg.sv
// ----------------------------------------------------------------------------
// cst_pkg
// Shared types and constants of the control stanza tokenizer: event codes,
// character codes, the parser flag set and its reset value.
// ----------------------------------------------------------------------------
package cst_pkg;

   localparam int LINE_BITS_DEFAULT = 24;

   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;

   // end-of-input sequencing: two virtual newlines, then done
   localparam logic [1:0] EOI_DONE_STEP = 2'd2;

   typedef enum logic [3:0] {
      EV_IGNORED    = 4'd0,
      EV_KEY_BYTE   = 4'd1,
      EV_KEY_END    = 4'd2,
      EV_VALUE_BYTE = 4'd3,
      EV_CONT_BYTE  = 4'd4,
      EV_FIELD_END  = 4'd5,
      EV_DROPPED    = 4'd6,
      EV_RECORD_END = 4'd7,
      EV_ERROR      = 4'd8,
      EV_DONE       = 4'd9
   } event_type;

   typedef struct packed {
      logic colon_just_seen;
      logic at_line_start;
      logic first_char_pending;
      logic in_value;
      logic record_has_field;
      logic error_seen;
   } flags_type;

   localparam flags_type FLAGS_RESET = '{
      colon_just_seen:    1'b0,
      at_line_start:      1'b1,
      first_char_pending: 1'b1,
      in_value:           1'b0,
      record_has_field:   1'b0,
      error_seen:         1'b0
   };

endpackage

### rtl/control_stanza_tokenizer_top.sv
// ----------------------------------------------------------------------------
// control_stanza_tokenizer_top
// Tokenizer for "Key: value" stanza streams, one event per text byte.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one request: a text byte (req_op = 0) or end of input
//   (req_op = 1). rsp_* carries result events; rsp_last marks the final
//   event of a request. csr_write_enable/csr_write_data set strict mode;
//   write it only while the block is idle.
// Flow and throughput:
//   A request lands in an input register; its first event is then
//   registered in the result register. One byte per cycle is sustained
//   while rsp_ready stays high. End of input gives two virtual newlines
//   (unless an error is recorded), then done, from the single result
//   register emitting one event per cycle while it is not stalled.
// Reset:
//   Synchronous reset clears strict mode and both registers and sets the
//   parser flags and line count to reset values (line 1). After done the
//   parser state returns to reset values; strict mode keeps its value.
// Stall:
//   While rsp_ready is low the result register holds; the input register
//   still takes one request, then req_ready drops until the result drains.
// ----------------------------------------------------------------------------
module control_stanza_tokenizer_top
   import cst_pkg::*;
#(
   parameter int LINE_BITS = LINE_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_op,
   input  logic [7:0]           req_data_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [3:0]           rsp_event_res,
   output logic [7:0]           rsp_out_byte,
   output logic [LINE_BITS-1:0] rsp_line_number,
   output logic                 rsp_last,
   input  logic                 csr_write_enable,
   input  logic                 csr_write_data
);

   logic                 strict_ff;
   flags_type            flags_ff;
   logic [LINE_BITS-1:0] line_ff;

   logic                 in_valid_ff;
   logic                 in_op_ff;
   logic [7:0]           in_byte_ff;
   logic [1:0]           step_ff;

   logic                 out_valid_ff;
   event_type            out_event_ff;
   logic [7:0]           out_byte_ff;
   logic [LINE_BITS-1:0] out_line_ff;
   logic                 out_last_ff;

   flags_type            feed_flags;
   logic [LINE_BITS-1:0] feed_line;
   event_type            feed_event;
   logic [7:0]           feed_byte;
   logic [7:0]           step_byte;

   logic out_free;
   logic fire;
   logic emit_done;
   logic consume;

   assign step_byte = in_op_ff ? CH_NL : in_byte_ff;

   cst_feed #(
      .LINE_BITS (LINE_BITS)
   ) u_feed (
      .flags       (flags_ff),
      .line_count  (line_ff),
      .strict_mode (strict_ff),
      .data_byte   (step_byte),
      .flags_next  (feed_flags),
      .line_next   (feed_line),
      .event_res   (feed_event),
      .out_byte    (feed_byte)
   );

   assign out_free  = !out_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && out_free;
   assign emit_done = in_op_ff && (flags_ff.error_seen || step_ff == EOI_DONE_STEP);
   assign consume   = fire && (!in_op_ff || emit_done);
   assign req_ready = !in_valid_ff || consume;

   always_ff @(posedge clock) begin
      if (reset) begin
         strict_ff <= 1'b0;
      end else if (csr_write_enable) begin
         strict_ff <= csr_write_data;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (consume) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_op_ff   <= req_op;
         in_byte_ff <= req_data_byte;
      end
   end

   // parser state and end-of-input sequencing
   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= FLAGS_RESET;
         line_ff  <= LINE_BITS'(1);
         step_ff  <= 2'd0;
      end else if (fire) begin
         if (emit_done) begin
            flags_ff <= FLAGS_RESET;
            line_ff  <= LINE_BITS'(1);
            step_ff  <= 2'd0;
         end else begin
            flags_ff <= feed_flags;
            line_ff  <= feed_line;
            if (in_op_ff) begin
               step_ff <= step_ff + 2'd1;
            end
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (fire) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         if (emit_done) begin
            out_event_ff <= EV_DONE;
            out_byte_ff  <= 8'h00;
            out_line_ff  <= flags_ff.error_seen ? line_ff : '0;
            out_last_ff  <= 1'b1;
         end else begin
            out_event_ff <= feed_event;
            out_byte_ff  <= feed_byte;
            out_line_ff  <= line_ff;
            out_last_ff  <= !in_op_ff;
         end
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_event_res   = out_event_ff;
   assign rsp_out_byte    = out_byte_ff;
   assign rsp_line_number = out_line_ff;
   assign rsp_last        = out_last_ff;

endmodule

### rtl/cst_feed.sv
// ----------------------------------------------------------------------------
// cst_feed
// One tokenizer step: classifies one byte against the current parser flags
// and gives the event, the reported byte and line, and the next flags/line.
// ----------------------------------------------------------------------------
module cst_feed
   import cst_pkg::*;
#(
   parameter int LINE_BITS = LINE_BITS_DEFAULT
) (
   input  flags_type              flags,
   input  logic [LINE_BITS-1:0]   line_count,
   input  logic                   strict_mode,
   input  logic [7:0]             data_byte,
   output flags_type              flags_next,
   output logic [LINE_BITS-1:0]   line_next,
   output event_type              event_res,
   output logic [7:0]             out_byte
);

   always_comb begin
      flags_next = flags;
      line_next  = line_count;
      event_res  = EV_IGNORED;
      out_byte   = 8'h00;

      if (flags.error_seen) begin
         // hold everything, line count frozen
      end else if (data_byte == CH_NL) begin
         flags_next.colon_just_seen = 1'b0;
         if (!flags.at_line_start && !flags.in_value && strict_mode) begin
            flags_next.error_seen = 1'b1;
            event_res             = EV_ERROR;
         end else begin
            if (flags.at_line_start) begin
               if (flags.record_has_field) begin
                  event_res                   = EV_RECORD_END;
                  flags_next.record_has_field = 1'b0;
               end
            end else if (flags.in_value) begin
               event_res                   = EV_FIELD_END;
               flags_next.record_has_field = 1'b1;
            end else begin
               event_res = EV_DROPPED;
            end
            flags_next.at_line_start      = 1'b1;
            flags_next.first_char_pending = 1'b1;
            flags_next.in_value           = 1'b0;
            if (line_count != '1) begin
               line_next = line_count + LINE_BITS'(1);
            end
         end
      end else if (data_byte == CH_COLON && flags.colon_just_seen) begin
         // drop repeated colon after the key
      end else if (data_byte == CH_COLON && !flags.in_value) begin
         flags_next.in_value           = 1'b1;
         flags_next.colon_just_seen    = 1'b1;
         flags_next.at_line_start      = 1'b0;
         flags_next.first_char_pending = 1'b1;
         event_res                     = EV_KEY_END;
      end else begin
         event_res = flags.in_value ? EV_VALUE_BYTE : EV_KEY_BYTE;
         out_byte  = data_byte;
         if (flags.first_char_pending) begin
            if (flags.colon_just_seen) begin
               flags_next.colon_just_seen    = 1'b0;
               flags_next.first_char_pending = 1'b0;
               if (data_byte == CH_SPACE) begin
                  event_res = EV_IGNORED;
                  out_byte  = 8'h00;
               end
            end else if (flags.at_line_start) begin
               flags_next.at_line_start      = 1'b0;
               flags_next.first_char_pending = 1'b0;
               if (data_byte == CH_SPACE || data_byte == CH_TAB) begin
                  if (!flags.record_has_field) begin
                     flags_next.error_seen = 1'b1;
                     event_res             = EV_ERROR;
                     out_byte              = 8'h00;
                  end else begin
                     flags_next.in_value = 1'b1;
                     event_res           = EV_CONT_BYTE;
                  end
               end
            end
         end
      end
   end

endmodule

### rtl/cst_checker.sv
// ----------------------------------------------------------------------------
// cst_checker
// Port-level checks of the tokenizer's result channel, bound to the top level.
// ----------------------------------------------------------------------------
module cst_checker
   import cst_pkg::*;
#(
   parameter int LINE_BITS = LINE_BITS_DEFAULT
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [3:0]           rsp_event_res,
   input logic [7:0]           rsp_out_byte,
   input logic [LINE_BITS-1:0] rsp_line_number,
   input logic                 rsp_last
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_res)
         && $stable(rsp_out_byte) && $stable(rsp_line_number) && $stable(rsp_last))
      else $error("stalled result changed");

   // done always closes the request
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res == EV_DONE |-> rsp_last)
      else $error("done without last");

   // byte carried only by key, value and continuation events
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res != EV_KEY_BYTE && rsp_event_res != EV_VALUE_BYTE
         && rsp_event_res != EV_CONT_BYTE |-> rsp_out_byte == 8'h00)
      else $error("stray byte on non-byte event");

   // a continuation starts with space or tab
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res == EV_CONT_BYTE |->
         rsp_out_byte == CH_SPACE || rsp_out_byte == CH_TAB)
      else $error("continuation byte not blank");

endmodule

bind control_stanza_tokenizer_top cst_checker #(
   .LINE_BITS (LINE_BITS)
) u_cst_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_event_res   (rsp_event_res),
   .rsp_out_byte    (rsp_out_byte),
   .rsp_line_number (rsp_line_number),
   .rsp_last        (rsp_last)
);

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stanza tokenizer testbench
// Drives text bytes and end-of-input requests into the tokenizer, predicts the
// event stream of every request with a software copy of the parser flags and
// line counter, and compares each result field by field. Strict mode is
// toggled between phases; both channels idle at random.
// ----------------------------------------------------------------------------
package stanza_check_pkg;
   import cst_pkg::*;

   localparam int LINE_W = LINE_BITS_DEFAULT;

   localparam logic OP_TEXT = 1'b0;
   localparam logic OP_END  = 1'b1;

   typedef struct {
      event_type         ev_code;
      logic [7:0]        data;
      logic [LINE_W-1:0] line;
      logic              last;
   } stanza_event_type;

   class stanza_scoreboard;
      stanza_event_type  expected_events[$];
      bit                strict_mode;
      bit                colon_just_seen;
      bit                at_line_start;
      bit                first_char_pending;
      bit                in_value;
      bit                record_has_field;
      bit                error_seen;
      logic [LINE_W-1:0] line_count;
      int                fail_count;

      function new();
         strict_mode = 1'b0;
         fail_count = 0;
         restart_parse();
      endfunction

      function void restart_parse();
         colon_just_seen = 1'b0;
         at_line_start = 1'b1;
         first_char_pending = 1'b1;
         in_value = 1'b0;
         record_has_field = 1'b0;
         error_seen = 1'b0;
         line_count = LINE_W'(1);
      endfunction

      function void add_event(event_type ev, logic [7:0] b, logic [LINE_W-1:0] line);
         expected_events.push_back('{ev, b, line, 1'b0});
      endfunction

      function void tokenize_byte(logic [7:0] c);
         logic [LINE_W-1:0] line;
         event_type         ev;
         line = line_count;
         // after an error everything is dropped and the line count freezes
         if (error_seen) begin
            add_event(EV_IGNORED, 8'h00, line);
            return;
         end
         if (c == CH_NL) begin
            colon_just_seen = 1'b0;
            if (at_line_start) begin
               ev = record_has_field ? EV_RECORD_END : EV_IGNORED;
               record_has_field = 1'b0;
            end else if (in_value) begin
               ev = EV_FIELD_END;
               record_has_field = 1'b1;
            end else if (strict_mode) begin
               error_seen = 1'b1;
               add_event(EV_ERROR, 8'h00, line);
               return;
            end else begin
               ev = EV_DROPPED;
            end
            at_line_start = 1'b1;
            first_char_pending = 1'b1;
            in_value = 1'b0;
            if (line_count != {LINE_W{1'b1}})
               line_count = line_count + LINE_W'(1);
            add_event(ev, 8'h00, line);
            return;
         end
         if (c == CH_COLON && colon_just_seen) begin
            add_event(EV_IGNORED, 8'h00, line);
            return;
         end
         if (c == CH_COLON && !in_value) begin
            in_value = 1'b1;
            colon_just_seen = 1'b1;
            at_line_start = 1'b0;
            first_char_pending = 1'b1;
            add_event(EV_KEY_END, 8'h00, line);
            return;
         end
         if (first_char_pending) begin
            if (colon_just_seen) begin
               // drop the single space after the key colon
               colon_just_seen = 1'b0;
               first_char_pending = 1'b0;
               if (c == CH_SPACE) begin
                  add_event(EV_IGNORED, 8'h00, line);
                  return;
               end
            end else if (at_line_start) begin
               at_line_start = 1'b0;
               first_char_pending = 1'b0;
               if (c == CH_SPACE || c == CH_TAB) begin
                  if (!record_has_field) begin
                     error_seen = 1'b1;
                     add_event(EV_ERROR, 8'h00, line);
                     return;
                  end
                  in_value = 1'b1;
                  add_event(EV_CONT_BYTE, c, line);
                  return;
               end
            end
         end
         add_event(in_value ? EV_VALUE_BYTE : EV_KEY_BYTE, c, line);
      endfunction

      function void note_request(logic op, logic [7:0] b);
         if (op == OP_TEXT) begin
            tokenize_byte(b);
         end else begin
            // end of input: two virtual newlines unless an error stops them
            if (!error_seen)
               tokenize_byte(CH_NL);
            if (!error_seen)
               tokenize_byte(CH_NL);
            add_event(EV_DONE, 8'h00, error_seen ? line_count : {LINE_W{1'b0}});
            restart_parse();
         end
         expected_events[expected_events.size() - 1].last = 1'b1;
      endfunction

      function void note_failure(string msg);
         fail_count++;
         if (fail_count <= 10)
            $display("MISMATCH: %s", msg);
      endfunction

      function void check_result(logic [3:0] ev, logic [7:0] b, logic [LINE_W-1:0] line,
                                 logic last);
         stanza_event_type want;
         if (expected_events.size() == 0) begin
            note_failure($sformatf("unexpected result ev=%0d byte=%h line=%0d last=%b",
                                   ev, b, line, last));
            return;
         end
         want = expected_events.pop_front();
         if (want.ev_code !== ev || want.data !== b || want.line !== line
             || want.last !== last)
            note_failure($sformatf(
               "expected ev=%0d byte=%h line=%0d last=%b, got ev=%0d byte=%h line=%0d last=%b",
               want.ev_code, want.data, want.line, want.last, ev, b, line, last));
      endfunction
   endclass
endpackage

module testbench;
   import cst_pkg::*;
   import stanza_check_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int LONG_HOLD_CYCLES = 80;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic              req_op;
   logic [7:0]        req_data_byte;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [3:0]        rsp_event_res;
   logic [7:0]        rsp_out_byte;
   logic [LINE_W-1:0] rsp_line_number;
   logic              rsp_last;
   logic              csr_write_enable;
   logic              csr_write_data;

   stanza_scoreboard sb;
   int               items_sent = 0;
   int               stall_cycles = 0;
   bit               calm_phase = 1'b0;
   bit               hold_armed = 1'b0;
   bit               hold_done = 1'b0;

   control_stanza_tokenizer_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_event_res    (rsp_event_res),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_line_number  (rsp_line_number),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_request(req_op, req_data_byte);
         if (rsp_valid && rsp_ready)
            sb.check_result(rsp_event_res, rsp_out_byte, rsp_line_number, rsp_last);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
   end

   initial begin
      wait (stall_cycles >= STALL_LIMIT);
      $display("testbench NOT OK");
      $finish;
   end

   // result side: random back-pressure bursts, one long hold when armed
   initial begin
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset)
         @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_armed && !hold_done) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
            hold_done = 1'b1;
            rsp_ready <= 1'b1;
         end else if (!calm_phase && $urandom_range(0, 9) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // entered and left at a falling edge; valid stays up between back-to-back requests
   task automatic send_request(logic op, logic [7:0] b);
      if (!calm_phase && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_data_byte <= b;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(logic [7:0] c);
      send_request(OP_TEXT, c);
   endtask

   task automatic send_end();
      send_request(OP_END, 8'($urandom_range(0, 255)));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.expected_events.size() != 0)
         @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_strict(bit value);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      sb.strict_mode = value;
      repeat (2) @(negedge clock);
   endtask

   function automatic logic [7:0] pick_key_byte(bit line_start);
      logic [7:0] b;
      do begin
         if ($urandom_range(0, 3) != 0)
            b = 8'h61 + 8'($urandom_range(0, 25));
         else
            b = 8'($urandom_range(0, 255));
      end while (b == CH_NL || b == CH_COLON
                 || (line_start && (b == CH_SPACE || b == CH_TAB)));
      return b;
   endfunction

   function automatic logic [7:0] pick_value_byte();
      logic [7:0] b;
      do
         b = 8'($urandom_range(0, 255));
      while (b == CH_NL);
      return b;
   endfunction

   // mostly well-formed stanzas with random content, some noise and broken lines
   task automatic send_stanza_text(int budget, bit with_pressure);
      int  first_item;
      int  kind;
      bit  paused;
      first_item = items_sent;
      paused = 1'b0;
      while (items_sent - first_item < budget) begin
         if (with_pressure && !hold_armed && items_sent - first_item >= 40)
            hold_armed = 1'b1;
         if (with_pressure && !paused && items_sent - first_item >= 120) begin
            wait_drained();
            paused = 1'b1;
         end
         // restart the parser soon after an error, else the rest is ignored
         if (sb.error_seen && $urandom_range(0, 3) != 0) begin
            send_end();
            continue;
         end
         kind = $urandom_range(0, 99);
         if (kind < 55) begin
            for (int i = 0; i < $urandom_range(1, 6); i++)
               send_text(pick_key_byte(i == 0));
            send_text(CH_COLON);
            if ($urandom_range(0, 9) == 0)
               send_text(CH_COLON);
            if ($urandom_range(0, 4) != 0)
               send_text(CH_SPACE);
            repeat ($urandom_range(0, 8)) send_text(pick_value_byte());
            send_text(CH_NL);
         end else if (kind < 70) begin
            send_text($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
            repeat ($urandom_range(0, 6)) send_text(pick_value_byte());
            send_text(CH_NL);
         end else if (kind < 82) begin
            send_text(CH_NL);
         end else if (kind < 88) begin
            for (int i = 0; i < $urandom_range(1, 5); i++)
               send_text(pick_key_byte(i == 0));
            send_text(CH_NL);
         end else if (kind < 94) begin
            send_end();
         end else begin
            repeat ($urandom_range(1, 4)) send_text(8'($urandom_range(0, 255)));
         end
      end
      send_end();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_op = OP_TEXT;
      req_data_byte = 8'h00;
      csr_write_enable = 1'b0;
      csr_write_data = 1'b0;
      sb = new();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_strict(1'b0);
      // continuation with no field, then bytes after the error, then done
      send_text(CH_SPACE);
      send_text(8'h78);
      send_end();
      // blank line outside a record
      send_text(CH_NL);
      // repeated colon, skipped space, colon inside a value, byte extremes
      send_text(8'h00);
      send_text(CH_COLON);
      send_text(CH_COLON);
      send_text(CH_SPACE);
      send_text(8'hFF);
      send_text(CH_COLON);
      send_text(CH_NL);
      // tab continuation
      send_text(CH_TAB);
      send_text(8'h76);
      send_text(CH_NL);
      // keyless line is dropped, empty line ends the record
      send_text(8'h61);
      send_text(CH_NL);
      send_text(CH_NL);
      // empty key, then end of input inside an open record
      send_text(CH_COLON);
      send_text(CH_NL);
      send_end();

      write_strict(1'b1);
      send_text(8'h7A);
      send_text(CH_NL);
      send_end();
      // first virtual newline hits a keyless line
      send_text(8'h71);
      send_end();

      write_strict(1'b0);
      send_stanza_text(185, 1'b1);
      write_strict(1'b1);
      send_stanza_text(155, 1'b0);
      write_strict(1'b0);
      calm_phase = 1'b1;
      send_stanza_text(95, 1'b0);

      wait_drained();
      repeat (20) @(negedge clock);
      if (sb.expected_events.size() != 0)
         sb.note_failure($sformatf("%0d expected results never arrived",
                                   sb.expected_events.size()));
      if (sb.fail_count == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end
endmodule
